// ----- sv/tlf_pkg.sv -----
// shared types, constants and codes of the text line filter
package tlf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

  // prefix kinds ahead of the final character
  localparam logic [1:0] PRE_NONE = 2'd0;
  localparam logic [1:0] PRE_CARET = 2'd1;
  localparam logic [1:0] PRE_META = 2'd2;

  // byte values
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_US = 8'h1F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_META_LO = 8'h80;
  localparam logic [7:0] CH_META_HI = 8'h9F;
  localparam logic [7:0] CH_OFFSET = 8'd64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // one classified byte, handed from front to back
  typedef struct packed {
    logic       has_num;
    logic       has_dollar;
    logic [1:0] pre;
    logic [7:0] ch;
  } job_t;

endpackage

// ----- sv/tlf_fifo.sv -----
// two-entry queue between the front and back parts
module tlf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

// ----- sv/tlf_front.sv -----
// front part: configuration, line state and classification of each byte
module tlf_front #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  tlf_pkg::in_item_t                item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             push,
  output tlf_pkg::job_t                    push_job,
  output logic [4*NUMBER_DIGITS-1:0]       push_num,
  input  logic                             full
);
  import tlf_pkg::*;

  localparam int NUM_W = 4 * NUMBER_DIGITS;

  logic [1:0]       number_mode;
  logic             show_ends;
  logic             squeeze_blank;
  logic             show_tabs;
  logic             show_nonprinting;

  logic [NUM_W-1:0] line_number;
  logic             at_line_start;
  logic [1:0]       blank_run;

  logic [NUM_W-1:0] line_number_next;
  logic             at_line_start_next;
  logic [1:0]       blank_run_next;

  logic [NUM_W-1:0] eff_num;
  logic             eff_start;
  logic [1:0]       eff_blank;
  logic             nl;
  logic             drop;
  logic             do_num;
  logic             accept;
  logic [7:0]       b;

  // decimal increment, holds at all nines
  function automatic logic [NUM_W-1:0] bcd_inc(input logic [NUM_W-1:0] v);
    logic [NUM_W-1:0] r;
    logic             carry;
    logic [3:0]       d;
    r = v;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (carry) begin
        if (d >= 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return carry ? v : r;
  endfunction

  assign cfg_ready = 1'b1;
  assign item_stall = full;
  assign accept = item_valid && !item_stall;
  assign push = accept && !drop;
  assign push_num = line_number_next;

  always_comb begin
    b = item.data_byte;
    eff_num = item.start_of_file ? '0 : line_number;
    eff_start = item.start_of_file ? 1'b1 : at_line_start;
    eff_blank = item.start_of_file ? 2'd0 : blank_run;
    nl = (b == CH_NL);

    // squeeze repeated empty lines
    if (squeeze_blank && nl && eff_start) begin
      blank_run_next = (eff_blank == 2'd3) ? 2'd3 : eff_blank + 2'd1;
      drop = (blank_run_next > 2'd1);
    end else begin
      blank_run_next = 2'd0;
      drop = 1'b0;
    end

    do_num = eff_start && !drop && (number_mode[1] ? !nl : number_mode[0]);
    line_number_next = do_num ? bcd_inc(eff_num) : eff_num;
    at_line_start_next = drop ? eff_start : nl;

    push_job.has_num = do_num;
    push_job.has_dollar = show_ends && nl;
    push_job.pre = PRE_NONE;
    push_job.ch = b;
    if (show_tabs && b == CH_TAB) begin
      push_job.pre = PRE_CARET;
      push_job.ch = CH_I;
    end else if (show_nonprinting) begin
      if (b < CH_TAB || (b >= CH_VT && b <= CH_US)) begin
        push_job.pre = PRE_CARET;
        push_job.ch = b + CH_OFFSET;
      end else if (b == CH_DEL) begin
        push_job.pre = PRE_CARET;
        push_job.ch = CH_QMARK;
      end else if (b >= CH_META_LO && b <= CH_META_HI) begin
        push_job.pre = PRE_META;
        push_job.ch = b - CH_OFFSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode <= 2'd0;
      show_ends <= 1'b0;
      squeeze_blank <= 1'b0;
      show_tabs <= 1'b0;
      show_nonprinting <= 1'b0;
      line_number <= '0;
      at_line_start <= 1'b1;
      blank_run <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUMBER_MODE:      number_mode <= cfg_data[1:0];
          REG_SHOW_ENDS:        show_ends <= cfg_data[0];
          REG_SQUEEZE_BLANK:    squeeze_blank <= cfg_data[0];
          REG_SHOW_TABS:        show_tabs <= cfg_data[0];
          REG_SHOW_NONPRINTING: show_nonprinting <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        line_number <= line_number_next;
        at_line_start <= at_line_start_next;
        blank_run <= blank_run_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_drop_keeps_line_start: assert property (@(posedge clk) disable iff (rst)
    accept && drop |=> at_line_start && line_number == $past(line_number))
    else $error("squeezed newline changed line state");
`endif

endmodule

// ----- sv/tlf_back.sv -----
// back part: expands each queued job into output bytes through an output register
module tlf_back #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  tlf_pkg::job_t              head_job,
  input  logic [4*NUMBER_DIGITS-1:0] head_num,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output tlf_pkg::out_item_t         result
);
  import tlf_pkg::*;

  localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [DIG_W-1:0] TOP_DIG = DIG_W'(NUMBER_DIGITS - 1);

  localparam logic [2:0] PH_NUM = 3'd0;
  localparam logic [2:0] PH_TAB = 3'd1;
  localparam logic [2:0] PH_DOLLAR = 3'd2;
  localparam logic [2:0] PH_M = 3'd3;
  localparam logic [2:0] PH_DASH = 3'd4;
  localparam logic [2:0] PH_CARET = 3'd5;
  localparam logic [2:0] PH_CHAR = 3'd6;

  logic             busy;
  logic [2:0]       phase;
  logic [DIG_W-1:0] dig;
  logic             lead;

  logic [2:0]       phase_next;
  logic [DIG_W-1:0] dig_next;
  logic             lead_next;
  logic [2:0]       cur_phase;
  logic [DIG_W-1:0] cur_dig;
  logic             cur_lead;
  logic [2:0]       pre_start;
  logic [3:0]       d;
  logic [7:0]       byte_out;
  logic             advance;
  logic             step;

  assign advance = !result_valid || !result_stall;
  assign step = head_valid && advance;
  assign pop = step && (cur_phase == PH_CHAR);

  always_comb begin
    case (head_job.pre)
      PRE_CARET: pre_start = PH_CARET;
      PRE_META:  pre_start = PH_M;
      default:   pre_start = PH_CHAR;
    endcase

    if (busy) begin
      cur_phase = phase;
      cur_dig = dig;
      cur_lead = lead;
    end else begin
      cur_phase = head_job.has_num ? PH_NUM : (head_job.has_dollar ? PH_DOLLAR : pre_start);
      cur_dig = TOP_DIG;
      cur_lead = 1'b1;
    end

    d = head_num[{cur_dig, 2'b00} +: 4];
    dig_next = cur_dig;
    lead_next = cur_lead;
    byte_out = head_job.ch;
    phase_next = PH_CHAR;

    case (cur_phase)
      PH_NUM: begin
        // leading zeros shown as spaces, the units digit always shown
        if (cur_lead && d == 4'd0 && cur_dig != '0) begin
          byte_out = CH_SPACE;
        end else begin
          byte_out = CH_ZERO + {4'd0, d};
          lead_next = 1'b0;
        end
        if (cur_dig == '0) begin
          phase_next = PH_TAB;
        end else begin
          phase_next = PH_NUM;
          dig_next = cur_dig - DIG_W'(1);
        end
      end
      PH_TAB: begin
        byte_out = CH_TAB;
        phase_next = head_job.has_dollar ? PH_DOLLAR : pre_start;
      end
      PH_DOLLAR: begin
        byte_out = CH_DOLLAR;
        phase_next = pre_start;
      end
      PH_M: begin
        byte_out = CH_M;
        phase_next = PH_DASH;
      end
      PH_DASH: begin
        byte_out = CH_DASH;
        phase_next = PH_CARET;
      end
      PH_CARET: begin
        byte_out = CH_CARET;
        phase_next = PH_CHAR;
      end
      default: begin
        byte_out = head_job.ch;
        phase_next = PH_CHAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.out_byte <= byte_out;
      result.last <= (cur_phase == PH_CHAR);
      phase <= phase_next;
      dig <= dig_next;
      lead <= lead_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= head_valid;
      end
      if (step) begin
        busy <= (cur_phase != PH_CHAR);
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_has_job: assert property (@(posedge clk) disable iff (rst) busy |-> head_valid)
    else $error("expansion in progress without a queued job");
`endif

endmodule

// ----- sv/text_line_filter_core.sv -----
// an accepted input transaction passes through the queue, then the back part's output register, to the result
// throughput: one output byte per cycle while a job is queued and result_stall is low; an item renders
// 1 byte for a plain byte and up to NUMBER_DIGITS+5 bytes, through the back part's single byte output
// a two-entry queue lets input transactions continue while a longer rendering drains
// reset (synchronous): configuration registers zero, line count zero, at line start, queue empty
module text_line_filter_core #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  tlf_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tlf_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlf_pkg::*;

  localparam int NUM_W = 4 * NUMBER_DIGITS;
  localparam int Q_W = NUM_W + $bits(job_t);

  logic             push;
  job_t             push_job;
  logic [NUM_W-1:0] push_num;
  logic             full;
  logic             pop;
  logic             head_valid;
  logic [Q_W-1:0]   head;
  job_t             head_job;
  logic [NUM_W-1:0] head_num;

  assign head_job = head[$bits(job_t)-1:0];
  assign head_num = head[Q_W-1:$bits(job_t)];

  tlf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_job   (push_job),
    .push_num   (push_num),
    .full       (full)
  );

  tlf_fifo #(.WIDTH(Q_W)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    ({push_num, push_job}),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tlf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .head_num     (head_num),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
